// ===== src/iapa_pkg.sv =====
// shared types and constants for the ip address pool allocator
package iapa_pkg;

    localparam int HOST_BITS_DEF = 8;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_NOT_ALLOC,
        STAT_RESERVED
    } status_t;

    typedef enum logic {
        KIND_ALLOC,
        KIND_FREE
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_LEAF,
        ST_UP,
        ST_SIB,
        ST_DOWN,
        ST_MARK,
        ST_FREE_CHK,
        ST_FREE_UP,
        ST_DONE
    } state_t;

endpackage

// ===== src/iapa_flag_ram.sv =====
// full-flag memory of the tree: one write port, one registered read port
module iapa_flag_ram
    import iapa_pkg::*;
#(
    parameter int AW = HOST_BITS_DEF + 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [2**AW];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/iapa_ctrl.sv =====
// sequencer: tree walks over the flag memory, free counter and result status
module iapa_ctrl
    import iapa_pkg::*;
#(
    parameter int HOST_BITS = HOST_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic                 has_preferred,
    input  logic [HOST_BITS-1:0] host,
    output logic                 res_valid,
    input  logic                 res_take,
    output status_t              res_status,
    output logic                 res_alloc,
    output logic [HOST_BITS-1:0] res_host,
    output logic [7:0]           res_free
);

    localparam int AW = HOST_BITS + 1;
    localparam int CW = (HOST_BITS > 8) ? HOST_BITS : 8;
    localparam logic [AW-1:0] ROOT      = AW'(1);
    localparam logic [AW-1:0] NODE_NET  = {1'b1, {HOST_BITS{1'b0}}};
    localparam logic [AW-1:0] NODE_SRV  = {AW{1'b1}};
    localparam logic [AW-1:0] NODE_BC   = {{HOST_BITS{1'b1}}, 1'b0};
    localparam logic [AW-1:0] NODE_PAIR = {1'b0, {HOST_BITS{1'b1}}};
    localparam logic [HOST_BITS-1:0] HOST_TOP = {HOST_BITS{1'b1}};
    localparam logic [HOST_BITS-1:0] HOST_BC  = {{(HOST_BITS-1){1'b1}}, 1'b0};
    localparam logic [CW-1:0] FREE_INIT = CW'(2**HOST_BITS - 3);

    state_t               state_reg, state_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [HOST_BITS-1:0] leaf_reg, leaf_next;
    kind_t                kind_reg, kind_next;
    status_t              status_reg, status_next;
    logic [CW-1:0]        free_reg, free_next;

    logic          wr_en, wr_data, rd_en, rd_data;
    logic [AW-1:0] wr_addr, rd_addr;

    logic          mark_go, down_go;
    logic [AW-1:0] mark_node, down_node;
    logic [AW-1:0] parent, sib, pick;
    logic [HOST_BITS-1:0] start;
    logic          reserved, clear_flag;

    iapa_flag_ram #(.AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            node_reg   <= '0;
            kind_reg   <= KIND_ALLOC;
            status_reg <= STAT_OK;
            free_reg   <= FREE_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            node_reg   <= node_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_reg <= leaf_next;
    end

    assign parent     = {1'b0, node_reg[AW-1:1]};
    assign sib        = {node_reg[AW-1:1], 1'b1};
    assign pick       = {node_reg[AW-2:0], rd_data};
    assign start      = has_preferred ? host : '0;
    assign reserved   = (host == '0) || (host == HOST_TOP) || (host == HOST_BC);
    assign clear_flag = (node_reg == NODE_NET) || (node_reg == NODE_SRV) ||
                        (node_reg == NODE_BC) || (node_reg == NODE_PAIR);

    always_comb
    begin
        state_next  = state_reg;
        node_next   = node_reg;
        leaf_next   = leaf_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        free_next   = free_reg;
        rd_en       = 1'b0;
        rd_addr     = node_reg;
        wr_en       = 1'b0;
        wr_addr     = node_reg;
        wr_data     = 1'b0;
        in_stall    = 1'b1;
        res_valid   = 1'b0;
        mark_go     = 1'b0;
        mark_node   = node_reg;
        down_go     = 1'b0;
        down_node   = node_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_data   = clear_flag;
                node_next = node_reg + AW'(1);
                if (node_reg == NODE_SRV)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    kind_next = kind_t'(kind);
                    if (kind == KIND_FREE)
                    begin
                        if (reserved)
                        begin
                            status_next = STAT_RESERVED;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = {1'b1, host};
                            node_next  = {1'b1, host};
                            state_next = ST_FREE_CHK;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ROOT;
                        node_next  = {1'b1, start};
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (rd_data)
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                if (!rd_data)
                begin
                    mark_go = 1'b1;
                end
                else
                begin
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (node_reg == ROOT)
                begin
                    down_go = 1'b1;
                end
                else if (!node_reg[0])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sib;
                    state_next = ST_SIB;
                end
                else
                begin
                    node_next = parent;
                end
            end
            ST_SIB:
            begin
                if (!rd_data)
                begin
                    if (sib[AW-1])
                    begin
                        mark_go   = 1'b1;
                        mark_node = sib;
                    end
                    else
                    begin
                        down_go   = 1'b1;
                        down_node = sib;
                    end
                end
                else
                begin
                    node_next  = parent;
                    state_next = ST_UP;
                end
            end
            ST_DOWN:
            begin
                if (pick[AW-1])
                begin
                    mark_go   = 1'b1;
                    mark_node = pick;
                end
                else
                begin
                    down_go   = 1'b1;
                    down_node = pick;
                end
            end
            ST_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = rd_data;
                if (!rd_data || parent == ROOT)
                begin
                    free_next   = free_reg - CW'(1);
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end
                else
                begin
                    node_next = parent;
                    rd_en     = 1'b1;
                    rd_addr   = {parent[AW-1:1], ~parent[0]};
                end
            end
            ST_FREE_CHK:
            begin
                if (!rd_data)
                begin
                    status_next = STAT_NOT_ALLOC;
                    state_next  = ST_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    node_next  = parent;
                    state_next = ST_FREE_UP;
                end
            end
            ST_FREE_UP:
            begin
                wr_en = 1'b1;
                if (node_reg == ROOT)
                begin
                    free_next   = free_reg + CW'(1);
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end
                else
                begin
                    node_next = parent;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // claim a free leaf and start the upward fill
        if (mark_go)
        begin
            wr_en      = 1'b1;
            wr_addr    = mark_node;
            wr_data    = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = {mark_node[AW-1:1], ~mark_node[0]};
            node_next  = mark_node;
            leaf_next  = mark_node[HOST_BITS-1:0];
            state_next = ST_MARK;
        end

        // descend toward the leftmost free leaf
        if (down_go)
        begin
            rd_en      = 1'b1;
            rd_addr    = {down_node[AW-2:0], 1'b0};
            node_next  = down_node;
            state_next = ST_DOWN;
        end
    end

    assign res_status = status_reg;
    assign res_alloc  = (kind_reg == KIND_ALLOC) && (status_reg == STAT_OK);
    assign res_host   = leaf_reg;
    assign res_free   = free_reg[7:0];

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("flag memory read and write hit the same entry");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_INIT)
        else $error("free count above pool size");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && status_reg == STAT_FULL) |-> (free_reg == '0))
        else $error("pool full reported with free hosts left");

    a_no_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_alloc) |->
        (leaf_reg != '0 && leaf_reg != HOST_TOP && leaf_reg != HOST_BC))
        else $error("reserved host handed out");

endmodule

// ===== src/ip_address_pool_allocator_top.sv =====
// top level of the ip address pool allocator
// Hands out and takes back host addresses of one subnet, one item at a time. A tree of
// subtree-full flags sits in a single-port-read flag memory, and every step of a walk costs
// one memory access. A free walks from its leaf up to the root; an allocate may climb toward
// the root, descend to the leftmost free leaf and fill flags all the way up again, and a
// failed request ends without a walk. A result held back by out_stall while the output
// register is still occupied delays the next item. After reset the flag memory is initialized
// by a pass over all its entries during which no item is taken; configuration writes are taken
// at any time. A new item is taken while a finished result still waits in the output register.
module ip_address_pool_allocator_top
    import iapa_pkg::*;
#(
    parameter int HOST_BITS = HOST_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] network_prefix,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        has_preferred,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] allocated_address,
    output logic [7:0]  free_count
);

    logic [31:0]          prefix_reg;
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [31:0]          addr_reg;
    logic [7:0]           free_reg;

    logic                 res_valid, res_take, res_alloc;
    status_t              res_status;
    logic [HOST_BITS-1:0] res_host;
    logic [7:0]           res_free;

    iapa_ctrl #(.HOST_BITS(HOST_BITS)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .has_preferred (has_preferred),
        .host          (address[HOST_BITS-1:0]),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res_status    (res_status),
        .res_alloc     (res_alloc),
        .res_host      (res_host),
        .res_free      (res_free)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                prefix_reg <= network_prefix;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg <= res_status;
            free_reg   <= res_free;
            addr_reg   <= res_alloc ? {prefix_reg[31:HOST_BITS], res_host} : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign allocated_address = addr_reg;
    assign free_count        = free_reg;

endmodule

// ===== bench/testbench.sv =====
// testbench for the ip address pool allocator: directed table, then random phases with a tree predictor
module testbench;
    import iapa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HB = HOST_BITS_DEF;
    localparam int unsigned HOSTS = 1 << HB;
    localparam int unsigned NODES = 2 * HOSTS - 1;
    localparam int unsigned LEAF0 = HOSTS - 1;
    localparam logic [31:0] HOST_MASK = HOSTS - 1;
    localparam int unsigned SETTLE_CYCLES = 4 * HB + 16;

    typedef struct packed {
        status_t     status;
        logic [31:0] addr;
        logic [7:0]  count;
    } lease_t;

    typedef struct packed {
        kind_t       kind;
        logic        pref;
        logic [31:0] address;
        logic        typed;
        lease_t      lease;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] network_prefix;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic        has_preferred;
    logic [31:0] address;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] allocated_address;
    logic [7:0]  free_count;

    bit          tree_full [NODES];
    int unsigned open_hosts;
    logic [31:0] subnet_prefix;
    lease_t      leases_due [$];
    int unsigned fault_count = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    script_row_t script [0:20] = '{
        '{KIND_ALLOC, 1'b0, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'hC0A8_0101, 8'd252}},
        '{KIND_ALLOC, 1'b1, 32'hFFFF_FFFE, 1'b1, '{STAT_OK, 32'hC0A8_0102, 8'd251}},
        '{KIND_ALLOC, 1'b1, 32'h0000_0000, 1'b1, '{STAT_OK, 32'hC0A8_0103, 8'd250}},
        '{KIND_ALLOC, 1'b1, 32'h1234_5680, 1'b1, '{STAT_OK, 32'hC0A8_0180, 8'd249}},
        '{KIND_ALLOC, 1'b1, 32'hFFFF_FF80, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_FREE,  1'b0, 32'h0000_0000, 1'b1, '{STAT_RESERVED, 32'h0, 8'd248}},
        '{KIND_FREE,  1'b0, 32'hFFFF_FFFF, 1'b1, '{STAT_RESERVED, 32'h0, 8'd248}},
        '{KIND_FREE,  1'b1, 32'hABCD_EFFE, 1'b1, '{STAT_RESERVED, 32'h0, 8'd248}},
        '{KIND_FREE,  1'b0, 32'h0000_00C8, 1'b1, '{STAT_NOT_ALLOC, 32'h0, 8'd248}},
        '{KIND_FREE,  1'b1, 32'hC0A8_0180, 1'b1, '{STAT_OK, 32'h0, 8'd249}},
        '{KIND_FREE,  1'b0, 32'h0000_0080, 1'b1, '{STAT_NOT_ALLOC, 32'h0, 8'd249}},
        '{KIND_ALLOC, 1'b1, 32'h0000_00FD, 1'b1, '{STAT_OK, 32'hC0A8_01FD, 8'd248}},
        '{KIND_ALLOC, 1'b1, 32'h7FFF_FFFD, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_ALLOC, 1'b1, 32'h0000_00FC, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_ALLOC, 1'b1, 32'h55AA_55FC, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_FREE,  1'b0, 32'h0000_0001, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_ALLOC, 1'b0, 32'h8000_0000, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_FREE,  1'b0, 32'h0000_00FD, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_ALLOC, 1'b1, 32'h0000_007F, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_ALLOC, 1'b1, 32'h0000_00AA, 1'b0, '{STAT_OK, 32'h0, 8'd0}},
        '{KIND_FREE,  1'b1, 32'hFFFF_FFAA, 1'b0, '{STAT_OK, 32'h0, 8'd0}}
    };

    ip_address_pool_allocator_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .network_prefix    (network_prefix),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .has_preferred     (has_preferred),
        .address           (address),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .allocated_address (allocated_address),
        .free_count        (free_count)
    );

    always #10 clk = ~clk;

    function automatic void reset_pool();
        int unsigned n;
        for (n = 0; n < NODES; n++)
        begin
            tree_full[n] = 1'b0;
        end
        tree_full[LEAF0] = 1'b1;
        tree_full[NODES - 1] = 1'b1;
        tree_full[NODES - 2] = 1'b1;
        tree_full[HOSTS - 2] = 1'b1;
        open_hosts = HOSTS - 3;
        subnet_prefix = '0;
    endfunction

    function automatic void set_full(int unsigned n);
        int unsigned sib;
        int unsigned par;
        tree_full[n] = 1'b1;
        while (n != 0 && tree_full[n])
        begin
            sib = n[0] ? n + 1 : n - 1;
            par = (n - 1) / 2;
            tree_full[par] = tree_full[sib];
            n = par;
        end
    endfunction

    function automatic void clear_to_root(int unsigned n);
        tree_full[n] = 1'b0;
        while (n != 0)
        begin
            n = (n - 1) / 2;
            tree_full[n] = 1'b0;
        end
    endfunction

    function automatic int unsigned lowest_open_under(int unsigned n);
        int unsigned left;
        while (n < LEAF0)
        begin
            left = 2 * n + 1;
            n = tree_full[left] ? left + 1 : left;
        end
        return n;
    endfunction

    function automatic int unsigned next_open_from(int unsigned leaf);
        int unsigned n;
        n = leaf;
        if (!tree_full[leaf])
            return leaf;
        while (n != 0)
        begin
            if (n[0] && !tree_full[n + 1])
                return lowest_open_under(n + 1);
            n = (n - 1) / 2;
        end
        return lowest_open_under(0);
    endfunction

    function automatic bit is_reserved(logic [31:0] host);
        return host == 0 || host == HOST_MASK || host == HOST_MASK - 1;
    endfunction

    function automatic lease_t serve_request(kind_t k, logic pref, logic [31:0] a);
        lease_t      r;
        logic [31:0] host;
        int unsigned leaf;
        host = a & HOST_MASK;
        r = '{STAT_OK, 32'h0, 8'h0};
        if (k == KIND_ALLOC)
        begin
            if (tree_full[0])
                r.status = STAT_FULL;
            else
            begin
                leaf = next_open_from(LEAF0 + (pref ? host : 0));
                set_full(leaf);
                open_hosts--;
                r.addr = (subnet_prefix & ~HOST_MASK) | (leaf - LEAF0);
            end
        end
        else
        begin
            leaf = LEAF0 + host;
            if (is_reserved(host))
                r.status = STAT_RESERVED;
            else if (!tree_full[leaf])
                r.status = STAT_NOT_ALLOC;
            else
            begin
                clear_to_root(leaf);
                open_hosts++;
            end
        end
        r.count = open_hosts[7:0];
        return r;
    endfunction

    // a host currently handed out, or a random one when none is
    function automatic logic [31:0] pick_taken_host();
        int unsigned start;
        int unsigned i;
        logic [31:0] h;
        start = $urandom_range(0, HOSTS - 1);
        for (i = 0; i < HOSTS; i++)
        begin
            h = (start + i) % HOSTS;
            if (!is_reserved(h) && tree_full[LEAF0 + h])
                return h;
        end
        return $urandom_range(0, HOSTS - 1);
    endfunction

    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic write_prefix(logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        network_prefix <= value;
        do @(posedge clk); while (!cfg_ready);
        subnet_prefix = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(kind_t k, logic pref, logic [31:0] a, logic typed, lease_t fixed);
        int unsigned gap;
        lease_t      due;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        has_preferred <= pref;
        address <= a;
        do @(posedge clk); while (in_stall);
        due = serve_request(k, pref, a);
        leases_due.push_back(typed ? fixed : due);
    endtask

    // sender holds off until every pending item has come back
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (leases_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] prefix, int unsigned items, int unsigned alloc_pct);
        int unsigned i;
        int unsigned roll;
        kind_t       k;
        logic        pref;
        logic [31:0] a;
        quiesce();
        write_prefix(prefix);
        for (i = 0; i < items; i++)
        begin
            pref = $urandom_range(0, 1);
            a = $urandom;
            if ($urandom_range(1, 100) <= alloc_pct)
                k = KIND_ALLOC;
            else
            begin
                k = KIND_FREE;
                roll = $urandom_range(1, 10);
                if (roll <= 8)
                    a = (a & ~HOST_MASK) | pick_taken_host();
                else if (roll == 9)
                    a = (a & ~HOST_MASK) | (HOST_MASK - $urandom_range(0, 2) + 1) % HOSTS;
            end
            send_item(k, pref, a, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int unsigned i;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        network_prefix = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        has_preferred = 1'b0;
        address = '0;
        reset_pool();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_prefix(32'hC0A8_01FF);
        for (i = 0; i <= 20; i++)
        begin
            send_item(script[i].kind, script[i].pref, script[i].address,
                      script[i].typed, script[i].lease);
        end

        run_phase(32'h0000_0000, 280, 55);
        // mostly allocates: runs the pool dry and keeps asking
        run_phase(32'hFFFF_FFFF, 320, 95);
        run_phase($urandom, 250, 25);
        run_phase($urandom, 200, 50);

        quiesce();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold;
        int unsigned taken;
        lease_t      want;
        taken = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // long hold-offs so the block backs up into its input
            if (taken == 200 || taken == 820)
                hold = 400;
            else
                hold = draw_gap(recv_calm);
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (leases_due.size() == 0)
            begin
                $error("result with no item pending: status %0d address %h count %0d",
                       status, allocated_address, free_count);
                fault_count++;
            end
            else
            begin
                want = leases_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, status);
                    fault_count++;
                end
                if (allocated_address !== want.addr)
                begin
                    $error("allocated_address expected %h got %h", want.addr,
                           allocated_address);
                    fault_count++;
                end
                if (free_count !== want.count)
                begin
                    $error("free_count expected %0d got %0d", want.count, free_count);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== ip_address_pool_allocator_top.f =====
src/iapa_pkg.sv
src/iapa_flag_ram.sv
src/iapa_ctrl.sv
src/ip_address_pool_allocator_top.sv
bench/testbench.sv
